@@ sv/apta_pkg.sv @@
// ----------------------------------------------------------------------------
// apta_pkg
// Shared types and constants for the address pool trie allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package apta_pkg;

  localparam int MAX_HOST_BITS_DEF = 10;
  localparam int ADDR_W = 32;
  localparam int PFX_W = 6;
  localparam int HB_W = 5;
  localparam int CNT_W = 11;
  localparam int KIND_W = 2;
  localparam int ST_W = 3;
  localparam int CFG_IDX_W = 1;

  // Reset pool: network 0, /24.
  localparam logic [PFX_W-1:0] PFX_RESET = 6'd24;
  localparam logic [HB_W-1:0] HB_RESET = 5'd8;
  localparam logic [CNT_W-1:0] RESERVED_CNT = 11'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PFX = 1'b1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INIT = 2'd2;

  // Reserved leaves, in the order they are marked
  localparam logic [1:0] RSV_NET = 2'd0;
  localparam logic [1:0] RSV_BCAST = 2'd1;
  localparam logic [1:0] RSV_SERVER = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_RANGE   = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_BAD_CFG = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_DOWN,
    S_FCHK,
    S_LEAFW,
    S_UP,
    S_CLEAR,
    S_RSV
  } state_t;

  typedef struct packed {
    logic    load;
    logic    descend_rd;
    logic    descend;
    logic    rd_leaf;
    logic    wr_leaf;
    logic    leaf_val;
    logic    climb;
    logic    clr_start;
    logic    clr_step;
    logic    rsv_load;
    logic [1:0] rsv_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    finish;
    logic    grant;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic rdata;
    logic alloc_range_bad;
    logic free_range_bad;
    logic cfg_bad;
    logic last_level;
    logic idx_gt1;
    logic parent_gt1;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/apta_ram.sv @@
// ----------------------------------------------------------------------------
// apta_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module apta_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/apta_dp.sv @@
// ----------------------------------------------------------------------------
// apta_dp
// Datapath: config registers, pool registers, trie store and walk pointers.
// ----------------------------------------------------------------------------
`default_nettype none
module apta_dp #(
  parameter int MAX_HOST_BITS = apta_pkg::MAX_HOST_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [apta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [apta_pkg::ADDR_W-1:0]      cfg_data,
  input  wire  [apta_pkg::ADDR_W-1:0]      address,
  input  apta_pkg::cmd_t                   cmd,
  output apta_pkg::sts_t                   sts,
  output logic                             done,
  output logic [apta_pkg::ST_W-1:0]        status,
  output logic [apta_pkg::ADDR_W-1:0]      granted_address,
  output logic [apta_pkg::CNT_W-1:0]       free_count
);
  import apta_pkg::*;

  localparam int IW = MAX_HOST_BITS + 1;
  localparam int DEPTH = 1 << IW;

  logic [ADDR_W-1:0] net_address;
  logic [PFX_W-1:0]  prefix_length;
  logic [ADDR_W-1:0] pool_net;
  logic [HB_W-1:0]   hb;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] host;
  logic [IW-1:0]     idx;
  logic [HB_W-1:0]   level;
  logic [IW-1:0]     clr;
  logic              cur_v;

  logic              we;
  logic [IW-1:0]     waddr;
  logic              wdata;
  logic [IW-1:0]     raddr;
  logic              rdata;

  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] bcast;
  logic [ADDR_W-1:0] one_hb;
  logic [PFX_W-1:0]  hb_new;
  logic [ADDR_W-1:0] mask_new;
  logic              bit_n;
  logic [HB_W-1:0]   level_n;
  logic [ADDR_W-1:0] host_n;
  logic [IW-1:0]     idx_n;
  logic [IW-1:0]     parent;
  logic [ADDR_W-1:0] rsv_host;

  function automatic logic [IW-1:0] leaf_of(input logic [ADDR_W-1:0] one,
                                            input logic [ADDR_W-1:0] h);
    logic [ADDR_W-1:0] s;
    s = one + h;
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] child_of(input logic [IW-1:0] i,
                                             input logic [ADDR_W-1:0] h,
                                             input logic [HB_W-1:0] lv);
    return {i[IW-2:0], h[lv - 5'd1]};
  endfunction

  apta_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_trie (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    mask     = ~(32'hFFFF_FFFF << hb);
    bcast    = pool_net | mask;
    one_hb   = 32'd1 << hb;
    hb_new   = 6'd32 - prefix_length;
    mask_new = ~(32'hFFFF_FFFF << hb_new);
    bit_n    = host[level - 5'd1] ^ rdata;
    level_n  = level - 5'd1;
    host_n   = (host & ~(32'd1 << level_n)) | ({31'd0, bit_n} << level_n);
    idx_n    = {idx[IW-2:0], bit_n};
    parent   = idx >> 1;
    case (cmd.rsv_sel)
      RSV_NET:    rsv_host = '0;
      RSV_BCAST:  rsv_host = mask;
      default:    rsv_host = 32'd1;
    endcase

    sts.rdata           = rdata;
    sts.alloc_range_bad = (addr_r > bcast) || (addr_r < pool_net);
    sts.free_range_bad  = (addr_r >= bcast) || (addr_r <= pool_net + 32'd1);
    sts.cfg_bad         = (prefix_length < 6'd1) || (prefix_length > 6'd30) ||
                          (hb_new > PFX_W'(MAX_HOST_BITS)) ||
                          ((net_address & mask_new) != '0);
    sts.last_level      = (level == 5'd1);
    sts.idx_gt1         = (idx > IW'(1));
    sts.parent_gt1      = (parent > IW'(1));
    sts.clr_last        = (clr == {IW{1'b1}});

    // Read port select
    if (cmd.load) begin
      raddr = IW'(1);
    end else if (cmd.descend_rd) begin
      raddr = child_of(idx, host, level);
    end else if (cmd.descend) begin
      raddr = child_of(idx_n, host_n, level_n);
    end else if (cmd.rd_leaf) begin
      raddr = leaf_of(one_hb, host);
    end else if (cmd.wr_leaf) begin
      raddr = idx ^ IW'(1);
    end else if (cmd.climb) begin
      raddr = parent ^ IW'(1);
    end else begin
      raddr = idx;
    end

    // Write port select
    we    = cmd.wr_leaf | cmd.climb | cmd.clr_step;
    if (cmd.wr_leaf) begin
      waddr = idx;
      wdata = cmd.leaf_val;
    end else if (cmd.climb) begin
      waddr = parent;
      wdata = cur_v & rdata;
    end else begin
      waddr = clr;
      wdata = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      net_address   <= '0;
      prefix_length <= PFX_RESET;
      pool_net      <= '0;
      hb            <= HB_RESET;
      count         <= RESERVED_CNT;
      clr           <= '0;
      done          <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cfg_we) begin
        case (cfg_index)
          REG_NET: net_address <= cfg_data;
          REG_PFX: prefix_length <= cfg_data[PFX_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_start) begin
        pool_net <= net_address;
        hb       <= hb_new[HB_W-1:0];
        count    <= RESERVED_CNT;
        clr      <= '0;
      end
      if (cmd.clr_step) begin
        clr <= clr + IW'(1);
      end
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= address;
      host   <= address & mask;
      idx    <= IW'(1);
      level  <= hb;
    end
    if (cmd.descend) begin
      idx   <= idx_n;
      host  <= host_n;
      level <= level_n;
    end
    if (cmd.rd_leaf) begin
      idx <= leaf_of(one_hb, host);
    end
    if (cmd.rsv_load) begin
      idx <= leaf_of(one_hb, rsv_host);
    end
    if (cmd.wr_leaf) begin
      cur_v <= cmd.leaf_val;
    end
    if (cmd.climb) begin
      idx   <= parent;
      cur_v <= cur_v & rdata;
    end
    if (cmd.finish) begin
      status          <= cmd.status;
      granted_address <= cmd.grant ? pool_net + host : '0;
      free_count      <= one_hb[CNT_W-1:0] - count;
    end
  end
endmodule
`default_nettype wire

@@ sv/apta_ctrl.sv @@
// ----------------------------------------------------------------------------
// apta_ctrl
// Controller: sequences the walk down, the climb back up, clear and reserve.
// ----------------------------------------------------------------------------
`default_nettype none
module apta_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [apta_pkg::KIND_W-1:0]  kind,
  input  apta_pkg::sts_t               sts,
  output apta_pkg::cmd_t               cmd,
  output logic                         busy
);
  import apta_pkg::*;

  state_t            state, state_next;
  logic [KIND_W-1:0] op, op_next;
  logic [1:0]        rsv, rsv_next;
  logic              quiet, quiet_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op    <= KIND_INIT;
      rsv   <= RSV_NET;
      quiet <= 1'b1;
    end else begin
      state <= state_next;
      op    <= op_next;
      rsv   <= rsv_next;
      quiet <= quiet_next;
    end
  end

  always_comb begin
    logic climb_done;
    state_next  = state;
    op_next     = op;
    rsv_next    = rsv;
    quiet_next  = quiet;
    cmd         = '0;
    cmd.status  = ST_OK;
    cmd.rsv_sel = rsv;
    climb_done  = 1'b0;
    busy        = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          op_next    = kind;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        case (op)
          KIND_ALLOC: begin
            if (sts.rdata) begin
              cmd.finish = 1'b1;
              cmd.status = ST_NO_FREE;
              state_next = S_IDLE;
            end else if (sts.alloc_range_bad) begin
              cmd.finish = 1'b1;
              cmd.status = ST_RANGE;
              state_next = S_IDLE;
            end else begin
              cmd.descend_rd = 1'b1;
              state_next     = S_DOWN;
            end
          end
          KIND_FREE: begin
            if (sts.free_range_bad) begin
              cmd.finish = 1'b1;
              cmd.status = ST_RANGE;
              state_next = S_IDLE;
            end else begin
              cmd.rd_leaf = 1'b1;
              state_next  = S_FCHK;
            end
          end
          KIND_INIT: begin
            if (sts.cfg_bad) begin
              cmd.finish = 1'b1;
              cmd.status = ST_BAD_CFG;
              state_next = S_IDLE;
            end else begin
              cmd.clr_start = 1'b1;
              quiet_next    = 1'b0;
              rsv_next      = RSV_NET;
              state_next    = S_CLEAR;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            cmd.status = ST_RANGE;
            state_next = S_IDLE;
          end
        endcase
      end
      S_DOWN: begin
        cmd.descend = 1'b1;
        if (sts.last_level) begin
          state_next = S_LEAFW;
        end
      end
      S_FCHK: begin
        if (!sts.rdata) begin
          cmd.finish = 1'b1;
          cmd.status = ST_DOUBLE;
          state_next = S_IDLE;
        end else begin
          state_next = S_LEAFW;
        end
      end
      S_LEAFW: begin
        cmd.wr_leaf  = 1'b1;
        cmd.leaf_val = (op != KIND_FREE);
        cmd.cnt_inc  = (op == KIND_ALLOC);
        cmd.cnt_dec  = (op == KIND_FREE);
        if (sts.idx_gt1) begin
          state_next = S_UP;
        end else begin
          climb_done = 1'b1;
        end
      end
      S_UP: begin
        cmd.climb = 1'b1;
        if (!sts.parent_gt1) begin
          climb_done = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_RSV;
        end
      end
      S_RSV: begin
        cmd.rsv_load = 1'b1;
        state_next   = S_LEAFW;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Root reached: mark the next reserved leaf, or finish and report (no report after the reset pass)
    if (climb_done) begin
      if (op == KIND_INIT && rsv != RSV_SERVER) begin
        rsv_next   = rsv + 2'd1;
        state_next = S_RSV;
      end else begin
        cmd.finish = !(op == KIND_INIT && quiet);
        cmd.grant  = (op == KIND_ALLOC);
        cmd.status = ST_OK;
        state_next = S_IDLE;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/address_pool_trie_allocator.sv @@
// ----------------------------------------------------------------------------
// address_pool_trie_allocator
// Subnet address pool kept as a binary trie of full marks, one level per host bit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result is
// shown for one cycle with done high, and the receiver cannot stall it. The
// trie lives in a 2^(MAX_HOST_BITS+1) x 1 RAM with one read and one write
// port, so an allocate visits each trie level once going down and once going
// up, while a free reads its leaf directly and only climbs. Init sweeps the
// whole RAM clear, one entry per cycle, then marks the three reserved leaves
// with a climb each. The same clearing pass runs after reset, with busy high;
// configuration writes are taken at any time.
`default_nettype none
module address_pool_trie_allocator #(
  parameter int MAX_HOST_BITS = apta_pkg::MAX_HOST_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // request transfer
  input  wire                             start,
  output logic                            busy,
  input  wire  [apta_pkg::KIND_W-1:0]     kind,
  input  wire  [apta_pkg::ADDR_W-1:0]     address,
  // result transfer
  output logic                            done,
  output logic [apta_pkg::ST_W-1:0]       status,
  output logic [apta_pkg::ADDR_W-1:0]     granted_address,
  output logic [apta_pkg::CNT_W-1:0]      free_count,
  // register writes
  input  wire                             cfg_we,
  input  wire  [apta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [apta_pkg::ADDR_W-1:0]     cfg_data
);
  import apta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  apta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  apta_dp #(.MAX_HOST_BITS(MAX_HOST_BITS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .address         (address),
    .cmd             (cmd),
    .sts             (sts),
    .done            (done),
    .status          (status),
    .granted_address (granted_address),
    .free_count      (free_count)
  );

`ifndef SYNTH
  // an accepted request always keeps the block busy next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  // only a successful allocate grants an address
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (granted_address == '0))
    else $error("address granted on failing result");

  // the result strobe is a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif
endmodule
`default_nettype wire
